@@ src/version_masked_template_matcher_macros.svh @@
// assertion macros for the version-masked template matcher
// used by the top level; no other dependencies
`ifndef VERSION_MASKED_TEMPLATE_MATCHER_MACROS_SVH
`define VERSION_MASKED_TEMPLATE_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted (active low)
`define VMTM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// clocked check, always on
`define VMTM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VMTM_ASSERT(label, clk, rst_n, prop, msg)
`define VMTM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ src/vmtm_pkg.sv @@
// shared types, character codes and the read-only template table
// for the version-masked template matcher; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vmtm_pkg;

    // character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_X   = 8'h58;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_US  = 8'h5F;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // normalized character stream item
    typedef enum logic {
        ITEM_CHAR = 1'b0,
        ITEM_END  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  ch;
    } norm_item_t;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
    } q_status_t;

    // template storage: rows are right-justified byte strings
    localparam int TPL_ROWS  = 23;
    localparam int TPL_WIDTH = 128;
    localparam int TPL_POS_W = 12;

    typedef logic [8*TPL_WIDTH-1:0] tpl_row_t;

    // recurring pieces of the templates
    localparam S_MOZ = {"Moz", "illa/X"};
    localparam S_CHR = {"Chr", "ome/X"};
    localparam S_SAF = {"Saf", "ari/X"};
    localparam S_FFX = {"Fire", "fox/X"};
    localparam S_EDG = {"Ed", "g/X"};
    localparam S_OPR = {"OP", "R/X"};
    localparam S_ELE = {"Elec", "tron/X"};
    localparam S_KIT = " AppleWebKit/X (KHTML, like Gecko) ";
    localparam S_AND = " (Linux; Android X; K)";
    localparam S_MAC = " (Macintosh; Intel Mac OS X X)";
    localparam S_WIN = " (Windows NT X; WinX; xX)";
    localparam S_IPH = " (iPhone; CPU iPhone OS X like Mac OS X)";

    localparam tpl_row_t TPL_TABLE [TPL_ROWS] = '{
        {S_MOZ, S_AND, S_KIT, S_CHR, " Mobile ", S_SAF},
        {S_MOZ, S_AND, S_KIT, S_CHR, " ", S_SAF},
        {S_MOZ, S_AND, S_KIT, "Samsung", "Browser/X ", S_CHR, " Mobile ", S_SAF},
        {S_MOZ, " (Linux; Android X; XRI Build/UKQX; wv)", S_KIT, "Version/X ", S_CHR,
         " Mobile ", S_SAF, " median"},
        {S_MOZ, S_MAC, S_KIT, S_CHR, " ", S_SAF},
        {S_MOZ, S_MAC, S_KIT, S_CHR, " ", S_SAF, " ", S_EDG},
        {S_MOZ, S_MAC, S_KIT, S_CHR, " ", S_SAF, " ", S_OPR},
        {S_MOZ, S_MAC, S_KIT, "Version/X ", S_SAF},
        {S_MOZ, " (Macintosh; Intel Mac OS X X; rv:X) Gecko/X ", S_FFX},
        {S_MOZ, S_WIN, S_KIT, S_CHR, " ", S_SAF},
        {S_MOZ, S_WIN, S_KIT, S_CHR, " ", S_SAF, " ", S_EDG},
        {S_MOZ, S_WIN, S_KIT, S_CHR, " ", S_SAF, " ", S_OPR},
        {S_MOZ, S_WIN, S_KIT, S_CHR, " Ya", "Browser/X ", S_SAF},
        {S_MOZ, S_WIN, S_KIT, "Scalboost", "Browser/X ", S_CHR, " ", S_ELE, " ", S_SAF},
        {S_MOZ, S_WIN, S_KIT, "obsi", "dian/X ", S_CHR, " ", S_ELE, " ", S_SAF},
        {S_MOZ, " (Windows NT X; WinX; xX; rv:X) Gecko/X ", S_FFX},
        {S_MOZ, " (XX; CrOS xX X)", S_KIT, S_CHR, " ", S_SAF},
        {S_MOZ, " (XX; Linux xX)", S_KIT, S_CHR, " ", S_SAF},
        {S_MOZ, " (XX; Linux xX; rv:X) Gecko/X ", S_FFX},
        {S_MOZ, " (XX; Ubuntu; Linux xX; rv:X) Gecko/X ", S_FFX},
        {S_MOZ, S_IPH, S_KIT, "Cri", "OS/X Mobile/XEX ", S_SAF},
        {S_MOZ, S_IPH, S_KIT, "Mobile/XEX"},
        {S_MOZ, S_IPH, S_KIT, "Version/X Mobile/XEX ", S_SAF}
    };

    // number of characters in a stored row
    function automatic int tpl_row_len(input tpl_row_t row);
        int n;
        n = 0;
        for (int i = 0; i < TPL_WIDTH; i++) begin
            if (row[8*i +: 8] != CH_NUL) begin
                n++;
            end
        end
        return n;
    endfunction

    // character of a stored row at a position, zero past its end
    function automatic logic [7:0] tpl_char(input int row, input logic [TPL_POS_W-1:0] pos);
        int         len;
        logic [7:0] ch;
        len = tpl_row_len(TPL_TABLE[row]);
        ch  = CH_NUL;
        for (int i = 0; i < TPL_WIDTH; i++) begin
            if (i < len && int'(pos) == i) begin
                ch = TPL_TABLE[row][8*(len-1-i) +: 8];
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ src/version_masked_template_matcher.sv @@
// throughput: one string byte per cycle, sustained; the input stalls only when a terminator
//   meets a verdict still waiting, once the terminator and one more entry fill the queue
// result: m_tvalid rises at the edge where the back end takes the terminator from the queue
//   into the output register
// reset: synchronous active-low aresetn clears the queue, the run flag, the length,
//   the overflow flag and the output valid, and sets every template bit alive
`timescale 1ns / 1ps
`default_nettype none

`include "version_masked_template_matcher_macros.svh"

module version_masked_template_matcher
    import vmtm_pkg::*;
#(
    parameter int MAX_NORM_LEN     = 1023,
    parameter int TEMPLATE_COUNT   = 23,
    parameter int TEMPLATE_MAX_LEN = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] text_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata     // [0] is_known_browser, [7:1] zero
);

    logic       push_valid;
    norm_item_t push_item;
    q_status_t  q_status;
    norm_item_t head_item;
    logic       head_ready;
    logic       head_pop;
    logic       m_hit;

    // byte classification and run collapsing
    vmtm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_ready    (q_status.in_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // decoupling queue
    assign head_pop = q_status.out_valid && head_ready;

    vmtm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop_en     (head_pop),
        .status     (q_status),
        .head_item  (head_item)
    );

    // template comparison and verdict
    vmtm_back #(
        .MAX_NORM_LEN     (MAX_NORM_LEN),
        .TEMPLATE_COUNT   (TEMPLATE_COUNT),
        .TEMPLATE_MAX_LEN (TEMPLATE_MAX_LEN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_status.out_valid),
        .head_item  (head_item),
        .head_ready (head_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_hit      (m_hit)
    );

    assign m_tdata = {7'b0000000, m_hit};

    // checks
    `VMTM_ASSERT(a_term_to_queue, aclk, aresetn, (s_tvalid && s_tready && s_tdata == CH_NUL) |-> (push_valid && push_item.kind == ITEM_END), "terminator transaction did not enter the queue")
    `VMTM_ASSERT(a_push_has_room, aclk, aresetn, push_valid |-> q_status.in_ready, "push into a full queue")
    `VMTM_ASSERT(a_result_drains, aclk, aresetn, (m_tvalid && m_tready && !(head_pop && head_item.kind == ITEM_END)) |=> !m_tvalid, "result repeated after its transaction")

endmodule

`default_nettype wire

@@ src/vmtm_front.sv @@
// front end: accepts string bytes and collapses version runs into one 'X'
// depends on vmtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmtm_front
    import vmtm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] text_byte
    input  wire logic        q_ready,
    output logic             push_valid,
    output norm_item_t       push_item
);

    logic in_digit_run_reg;
    logic in_digit_run_next;
    logic accept;
    logic is_ver;
    logic is_term;

    // classify the incoming byte
    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign is_term  = (s_tdata == CH_NUL);
    assign is_ver   = (s_tdata >= CH_0 && s_tdata <= CH_9) ||
                      s_tdata == CH_DOT || s_tdata == CH_US;

    // one queue entry per normalized character or terminator
    always_comb begin
        push_valid     = accept && !(is_ver && in_digit_run_reg);
        push_item.kind = is_term ? ITEM_END : ITEM_CHAR;
        push_item.ch   = is_ver ? CH_X : s_tdata;
    end

    // run tracking, cleared by the terminator
    always_comb begin
        in_digit_run_next = in_digit_run_reg;
        if (accept) begin
            in_digit_run_next = !is_term && is_ver;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_digit_run_reg <= 1'b0;
        end else begin
            in_digit_run_reg <= in_digit_run_next;
        end
    end

endmodule

`default_nettype wire

@@ src/vmtm_queue.sv @@
// short queue of normalized items between front and back end
// depends on vmtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmtm_queue
    import vmtm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    input  norm_item_t push_item,
    input  wire logic  pop_en,
    output q_status_t  status,
    output norm_item_t head_item
);

    norm_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // status and head
    assign status.in_ready  = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign status.out_valid = (count_reg != '0);
    assign head_item        = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        unique case ({push_valid, pop_en})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ src/vmtm_back.sv @@
// back end: compares normalized characters against all templates in parallel
// and registers the verdict on the terminator; depends on vmtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmtm_back
    import vmtm_pkg::*;
#(
    parameter int MAX_NORM_LEN     = 1023,
    parameter int TEMPLATE_COUNT   = 23,
    parameter int TEMPLATE_MAX_LEN = 128
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  head_valid,
    input  norm_item_t head_item,
    output logic       head_ready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic       m_hit
);

    localparam int LEN_W = $clog2(MAX_NORM_LEN + 1);

    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          len_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic [TEMPLATE_COUNT-1:0] alive_reg;
    logic [TEMPLATE_COUNT-1:0] alive_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      m_hit_reg;
    logic                      m_hit_next;

    logic [7:0]                tpl_cur [TEMPLATE_COUNT];
    logic [TEMPLATE_COUNT-1:0] match_vec;
    logic [TEMPLATE_COUNT-1:0] end_vec;
    logic                      pop;
    logic                      hit;

    // template characters at the current position
    for (genvar t = 0; t < TEMPLATE_COUNT; t++) begin : g_tpl
        if (t < TPL_ROWS) begin : g_row
            assign tpl_cur[t] = (int'(len_reg) < TEMPLATE_MAX_LEN) ?
                                tpl_char(t, TPL_POS_W'(len_reg)) : CH_NUL;
        end else begin : g_empty
            assign tpl_cur[t] = CH_NUL;
        end
        assign match_vec[t] = (tpl_cur[t] == head_item.ch);
        assign end_vec[t]   = (tpl_cur[t] == CH_NUL);
    end

    // char items always drain, a terminator waits for the output register
    assign head_ready = (head_item.kind == ITEM_CHAR) || !m_valid_reg || m_tready;
    assign pop        = head_valid && head_ready;
    assign hit        = !ovf_reg && (len_reg != '0) && |(alive_reg & end_vec);

    // per-string match state
    always_comb begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        alive_next = alive_reg;
        if (pop) begin
            unique case (head_item.kind)
                ITEM_CHAR: begin
                    if (len_reg >= LEN_W'(MAX_NORM_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        alive_next = alive_reg & match_vec;
                        len_next   = len_reg + LEN_W'(1);
                    end
                end
                ITEM_END: begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    alive_next = {TEMPLATE_COUNT{1'b1}};
                end
                default: begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        if (pop && head_item.kind == ITEM_END) begin
            m_valid_next = 1'b1;
            m_hit_next   = hit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            alive_reg   <= {TEMPLATE_COUNT{1'b1}};
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            alive_reg   <= alive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_reg <= m_hit_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_hit    = m_hit_reg;

endmodule

`default_nettype wire
